FILE: rtl/assert_macros.svh
// assertion macros shared by the link controller modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SAW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/saw_pkg.sv
// types, codes and constants of the stop-and-wait link controller
// no dependencies
package saw_pkg;

  localparam int CMD_W  = 3;
  localparam int WORD_W = 32;
  localparam int SIZE_W = 9;
  localparam int CNT_W  = 4;

  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int SIZE_LIMIT_DEF   = 500;
  localparam logic [CNT_W-1:0] RETRY_LIMIT_RST = 4'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_RCV_CON  = 3'd0,
    CMD_RCV_FIN  = 3'd1,
    CMD_RCV_ACK  = 3'd2,
    CMD_RCV_DATA = 3'd3,
    CMD_CONNECT  = 3'd4,
    CMD_CLOSE    = 3'd5,
    CMD_SEND     = 3'd6,
    CMD_TIMER    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_CONSENT   = 2'd1,
    PH_CONNECTED = 2'd2,
    PH_SENDING   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    PK_CON  = 2'd0,
    PK_FIN  = 2'd1,
    PK_ACK  = 2'd2,
    PK_DATA = 2'd3
  } pkt_t;

  typedef enum logic [1:0] {
    TM_NONE = 2'd0,
    TM_STOP = 2'd1,
    TM_CONN = 2'd2,
    TM_DATA = 2'd3
  } tmr_t;

  typedef struct packed {
    logic              send_valid;
    pkt_t              send_type;
    logic [WORD_W-1:0] send_word;
    logic [SIZE_W-1:0] send_size;
    tmr_t              timer_cmd;
    logic              deliver_valid;
    logic [WORD_W-1:0] deliver_word;
    logic [SIZE_W-1:0] deliver_size;
    phase_t            link_state;
    logic              send_ready;
    logic              gave_up;
  } result_t;

endpackage

FILE: rtl/stop_and_wait_link_fsm_core.sv
// stop-and-wait link controller: connection set-up, one outstanding data word,
// duplicate-filtered delivery of received data
// depends on saw_pkg, saw_ctrl, saw_out_buf
//
// usage
//   input channel in_valid/in_ready carries one event transaction: in_cmd,
//   in_data_word, in_data_size
//   output channel out_valid/out_ready returns exactly one result transaction
//   per event: packet to the peer, timer command, delivered data, link state
//   cfg_we/cfg_data write the retransmit limit; write only while idle
// latency: the result is presented one cycle after the event is accepted
// throughput: one event per cycle; the link state registers update at the
//   accept edge, so the next event sees them at once
// a stalled receiver holds the single result register; in_ready then drops
//   until the result is taken, and accepts again in that same cycle
// reset: synchronous on rst_n; link idle, send open, retry count zero,
//   retransmit limit 5, no result pending
module stop_and_wait_link_fsm_core #(
  parameter int PAYLOAD_BITS = saw_pkg::PAYLOAD_BITS_DEF,
  parameter int SIZE_LIMIT   = saw_pkg::SIZE_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [saw_pkg::CMD_W-1:0]    in_cmd,
  input  logic [saw_pkg::WORD_W-1:0]   in_data_word,
  input  logic [saw_pkg::SIZE_W-1:0]   in_data_size,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_send_valid,
  output logic [1:0]                   out_send_type,
  output logic [saw_pkg::WORD_W-1:0]   out_send_word,
  output logic [saw_pkg::SIZE_W-1:0]   out_send_size,
  output logic [1:0]                   out_timer_cmd,
  output logic                         out_deliver_valid,
  output logic [saw_pkg::WORD_W-1:0]   out_deliver_word,
  output logic [saw_pkg::SIZE_W-1:0]   out_deliver_size,
  output logic [1:0]                   out_link_state,
  output logic                         out_send_ready,
  output logic                         out_gave_up,
  input  logic                         cfg_we,
  input  logic [saw_pkg::CNT_W-1:0]    cfg_data
);

  logic             fire;
  saw_pkg::result_t res;
  saw_pkg::result_t res_q;

  assign fire = in_valid && in_ready;

  saw_ctrl #(
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .SIZE_LIMIT   (SIZE_LIMIT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .cmd       (saw_pkg::cmd_t'(in_cmd)),
    .data_word (in_data_word),
    .data_size (in_data_size),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  saw_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (in_ready),
    .res_q     (res_q)
  );

  assign out_send_valid    = res_q.send_valid;
  assign out_send_type     = res_q.send_type;
  assign out_send_word     = res_q.send_word;
  assign out_send_size     = res_q.send_size;
  assign out_timer_cmd     = res_q.timer_cmd;
  assign out_deliver_valid = res_q.deliver_valid;
  assign out_deliver_word  = res_q.deliver_word;
  assign out_deliver_size  = res_q.deliver_size;
  assign out_link_state    = res_q.link_state;
  assign out_send_ready    = res_q.send_ready;
  assign out_gave_up       = res_q.gave_up;

endmodule

FILE: rtl/saw_ctrl.sv
// link state, retry and duplicate-filter registers with the event transition logic
// depends on saw_pkg and assert_macros.svh
`include "assert_macros.svh"

module saw_ctrl #(
  parameter int PAYLOAD_BITS = saw_pkg::PAYLOAD_BITS_DEF,
  parameter int SIZE_LIMIT   = saw_pkg::SIZE_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  saw_pkg::cmd_t                   cmd,
  input  logic [saw_pkg::WORD_W-1:0]      data_word,
  input  logic [saw_pkg::SIZE_W-1:0]      data_size,
  input  logic                            cfg_we,
  input  logic [saw_pkg::CNT_W-1:0]       cfg_data,
  output saw_pkg::result_t                res
);

  localparam int STORE_W = (PAYLOAD_BITS < saw_pkg::WORD_W) ? PAYLOAD_BITS : saw_pkg::WORD_W;

  saw_pkg::phase_t               phase_r, phase_nxt;
  logic [saw_pkg::CNT_W-1:0]     limit_r;
  logic [saw_pkg::CNT_W-1:0]     retry_r, retry_nxt;
  logic                          accept_r, accept_nxt;
  logic [STORE_W-1:0]            saved_word_r, saved_word_nxt;
  logic [saw_pkg::SIZE_W-1:0]    saved_size_r, saved_size_nxt;
  logic [STORE_W-1:0]            last_word_r, last_word_nxt;
  logic                          last_valid_r, last_valid_nxt;

  logic [STORE_W-1:0]            word_m;
  logic [saw_pkg::SIZE_W-1:0]    size_c;
  logic                          give_up;
  logic                          is_dup;

  assign word_m  = data_word[STORE_W-1:0];
  assign size_c  = (data_size > saw_pkg::SIZE_W'(SIZE_LIMIT)) ?
                   saw_pkg::SIZE_W'(SIZE_LIMIT) : data_size;
  assign give_up = (cmd == saw_pkg::CMD_TIMER) && (retry_r >= limit_r);
  assign is_dup  = last_valid_r && (last_word_r == word_m);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (cmd)
      saw_pkg::CMD_RCV_CON: begin
        if (phase_r == saw_pkg::PH_IDLE || phase_r == saw_pkg::PH_CONSENT)
          phase_nxt = saw_pkg::PH_CONNECTED;
      end
      saw_pkg::CMD_RCV_FIN: begin
        if (phase_r == saw_pkg::PH_CONSENT || phase_r == saw_pkg::PH_CONNECTED)
          phase_nxt = saw_pkg::PH_IDLE;
      end
      saw_pkg::CMD_RCV_ACK: begin
        if (phase_r == saw_pkg::PH_CONSENT || phase_r == saw_pkg::PH_SENDING)
          phase_nxt = saw_pkg::PH_CONNECTED;
      end
      saw_pkg::CMD_RCV_DATA: begin
        if (phase_r == saw_pkg::PH_CONNECTED || phase_r == saw_pkg::PH_SENDING)
          phase_nxt = saw_pkg::PH_CONNECTED;
      end
      saw_pkg::CMD_CONNECT: begin
        if (phase_r == saw_pkg::PH_IDLE)
          phase_nxt = saw_pkg::PH_CONSENT;
      end
      saw_pkg::CMD_CLOSE: begin
        if (phase_r != saw_pkg::PH_IDLE)
          phase_nxt = saw_pkg::PH_IDLE;
      end
      saw_pkg::CMD_SEND: begin
        if (accept_r && phase_r == saw_pkg::PH_CONNECTED)
          phase_nxt = saw_pkg::PH_SENDING;
      end
      saw_pkg::CMD_TIMER: begin
        if (give_up) begin
          if (phase_r == saw_pkg::PH_SENDING)
            phase_nxt = saw_pkg::PH_CONNECTED;
        end else if (phase_r == saw_pkg::PH_CONSENT) begin
          phase_nxt = saw_pkg::PH_IDLE;
        end else if (phase_r == saw_pkg::PH_CONNECTED) begin
          phase_nxt = saw_pkg::PH_SENDING;
        end
      end
    endcase
  end

  // result fields and datapath state
  always_comb begin
    res            = '0;
    retry_nxt      = give_up ? '0 : retry_r;
    accept_nxt     = accept_r;
    saved_word_nxt = saved_word_r;
    saved_size_nxt = saved_size_r;
    last_word_nxt  = last_word_r;
    last_valid_nxt = last_valid_r;
    res.gave_up    = give_up;
    unique case (cmd)
      saw_pkg::CMD_RCV_CON: begin
        if (phase_r == saw_pkg::PH_IDLE || phase_r == saw_pkg::PH_CONSENT) begin
          res.send_valid = 1'b1;
          res.send_type  = saw_pkg::PK_ACK;
          res.timer_cmd  = saw_pkg::TM_STOP;
        end
      end
      saw_pkg::CMD_RCV_FIN: begin
        if (phase_r == saw_pkg::PH_CONSENT || phase_r == saw_pkg::PH_CONNECTED) begin
          res.send_valid = 1'b1;
          res.send_type  = saw_pkg::PK_FIN;
        end
      end
      saw_pkg::CMD_RCV_ACK: begin
        if (phase_r == saw_pkg::PH_CONSENT) begin
          res.timer_cmd = saw_pkg::TM_STOP;
        end else if (phase_r == saw_pkg::PH_SENDING) begin
          res.timer_cmd = saw_pkg::TM_STOP;
          retry_nxt     = '0;
          accept_nxt    = 1'b1;
        end
      end
      saw_pkg::CMD_RCV_DATA: begin
        if (phase_r == saw_pkg::PH_CONNECTED || phase_r == saw_pkg::PH_SENDING) begin
          accept_nxt     = 1'b1;
          res.send_valid = 1'b1;
          res.send_type  = saw_pkg::PK_ACK;
          if (!is_dup) begin
            res.deliver_valid = 1'b1;
            res.deliver_word  = saw_pkg::WORD_W'(word_m);
            res.deliver_size  = size_c;
            last_word_nxt     = word_m;
            last_valid_nxt    = 1'b1;
          end
        end
      end
      saw_pkg::CMD_CONNECT: begin
        if (phase_r == saw_pkg::PH_IDLE) begin
          res.send_valid = 1'b1;
          res.send_type  = saw_pkg::PK_CON;
          res.timer_cmd  = saw_pkg::TM_CONN;
        end
      end
      saw_pkg::CMD_CLOSE: begin
        if (phase_r != saw_pkg::PH_IDLE) begin
          res.send_valid = 1'b1;
          res.send_type  = saw_pkg::PK_FIN;
        end
      end
      saw_pkg::CMD_SEND: begin
        if (accept_r && phase_r == saw_pkg::PH_CONNECTED) begin
          accept_nxt     = 1'b0;
          res.send_valid = 1'b1;
          res.send_type  = saw_pkg::PK_DATA;
          res.send_word  = saw_pkg::WORD_W'(word_m);
          res.send_size  = size_c;
          res.timer_cmd  = saw_pkg::TM_DATA;
          saved_word_nxt = word_m;
          saved_size_nxt = size_c;
        end
      end
      saw_pkg::CMD_TIMER: begin
        if (give_up) begin
          if (phase_r == saw_pkg::PH_SENDING) begin
            res.timer_cmd = saw_pkg::TM_STOP;
            accept_nxt    = 1'b1;
          end
        end else if (phase_r == saw_pkg::PH_CONSENT) begin
          res.send_valid = 1'b1;
          res.send_type  = saw_pkg::PK_FIN;
        end else if (phase_r == saw_pkg::PH_CONNECTED) begin
          res.timer_cmd = saw_pkg::TM_DATA;
        end else if (phase_r == saw_pkg::PH_SENDING) begin
          // resend of the saved transaction
          accept_nxt     = 1'b0;
          retry_nxt      = retry_r + 1'b1;
          res.send_valid = 1'b1;
          res.send_type  = saw_pkg::PK_DATA;
          res.send_word  = saw_pkg::WORD_W'(saved_word_r);
          res.send_size  = saved_size_r;
          res.timer_cmd  = saw_pkg::TM_DATA;
        end
      end
    endcase
    res.link_state = phase_nxt;
    res.send_ready = accept_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= saw_pkg::PH_IDLE;
      retry_r      <= '0;
      accept_r     <= 1'b1;
      saved_word_r <= '0;
      saved_size_r <= '0;
      last_word_r  <= '0;
      last_valid_r <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      retry_r      <= retry_nxt;
      accept_r     <= accept_nxt;
      saved_word_r <= saved_word_nxt;
      saved_size_r <= saved_size_nxt;
      last_word_r  <= last_word_nxt;
      last_valid_r <= last_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= saw_pkg::RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_data;
    end
  end

  `SAW_ASSERT_NEXT(a_refused_send_holds,
    fire && cmd == saw_pkg::CMD_SEND && !accept_r,
    $stable(phase_r) && !accept_r, "refused send changed link state")
  `SAW_ASSERT_NEXT(a_data_out_blocks_send,
    fire && res.send_valid && res.send_type == saw_pkg::PK_DATA,
    !accept_r && phase_r == saw_pkg::PH_SENDING, "data sent but send still open")
  `SAW_ASSERT_NOW(a_gave_up_clears_retry,
    res.gave_up, retry_nxt == '0 && cmd == saw_pkg::CMD_TIMER,
    "give-up without cleared retry count")

endmodule

FILE: rtl/saw_out_buf.sv
// result register between the transition logic and the output channel
// depends on saw_pkg and assert_macros.svh
`include "assert_macros.svh"

module saw_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  saw_pkg::result_t res,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             can_load,
  output saw_pkg::result_t res_q
);

  logic             valid_r, valid_nxt;
  saw_pkg::result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign res_q     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  `SAW_ASSERT_NOW(a_no_overwrite, load, can_load, "result register overwritten while full")
  `SAW_ASSERT_NEXT(a_load_shows, load, valid_r, "loaded transaction not presented")

endmodule

FILE: verif/saw_link_sb_pkg.sv
`timescale 1ns / 100ps
// scoreboard for the stop-and-wait link controller: link predictor and result checks
// depends on saw_pkg
package saw_link_sb_pkg;

  import saw_pkg::*;

  class link_scoreboard;
    logic [CNT_W-1:0]  limit;
    phase_t            ph;
    logic [CNT_W-1:0]  retries;
    logic              send_open;
    logic [WORD_W-1:0] held_word;
    logic [SIZE_W-1:0] held_size;
    logic [WORD_W-1:0] rx_word;
    logic              rx_seen;
    result_t           exp_results[$];
    int                mismatches;
    int                active_events;

    function new();
      limit         = RETRY_LIMIT_RST;
      ph            = PH_IDLE;
      retries       = '0;
      send_open     = 1'b1;
      held_word     = '0;
      held_size     = '0;
      rx_word       = '0;
      rx_seen       = 1'b0;
      mismatches    = 0;
      active_events = 0;
    endfunction

    function void set_limit(input logic [CNT_W-1:0] v);
      limit = v;
    endfunction

    function int pending();
      return exp_results.size();
    endfunction

    function void put_pkt(inout result_t r, input pkt_t t, input logic [WORD_W-1:0] w,
                          input logic [SIZE_W-1:0] s);
      r.send_valid = 1'b1;
      r.send_type  = t;
      r.send_word  = w;
      r.send_size  = s;
    endfunction

    // works out the result of one accepted event transaction
    function void note_event(input cmd_t c, input logic [WORD_W-1:0] w,
                             input logic [SIZE_W-1:0] sz);
      result_t           r;
      logic [SIZE_W-1:0] s;
      logic              give;
      phase_t            old_ph;
      r      = '0;
      old_ph = ph;
      s      = (sz > SIZE_LIMIT_DEF) ? SIZE_W'(SIZE_LIMIT_DEF) : sz;
      give   = (c == CMD_TIMER) && (retries >= limit);
      if (give) begin
        retries   = '0;
        r.gave_up = 1'b1;
      end
      case (c)
        CMD_RCV_CON: if (ph == PH_IDLE || ph == PH_CONSENT) begin
          put_pkt(r, PK_ACK, '0, '0);
          r.timer_cmd = TM_STOP;
          ph = PH_CONNECTED;
        end
        CMD_RCV_FIN: if (ph == PH_CONSENT || ph == PH_CONNECTED) begin
          put_pkt(r, PK_FIN, '0, '0);
          ph = PH_IDLE;
        end
        CMD_RCV_ACK: if (ph == PH_CONSENT) begin
          r.timer_cmd = TM_STOP;
          ph = PH_CONNECTED;
        end else if (ph == PH_SENDING) begin
          r.timer_cmd = TM_STOP;
          retries   = '0;
          send_open = 1'b1;
          ph = PH_CONNECTED;
        end
        CMD_RCV_DATA: if (ph == PH_CONNECTED || ph == PH_SENDING) begin
          send_open = 1'b1;
          put_pkt(r, PK_ACK, '0, '0);
          // duplicates are acked but not delivered
          if (!(rx_seen && rx_word == w)) begin
            r.deliver_valid = 1'b1;
            r.deliver_word  = w;
            r.deliver_size  = s;
            rx_word = w;
            rx_seen = 1'b1;
          end
          ph = PH_CONNECTED;
        end
        CMD_CONNECT: if (ph == PH_IDLE) begin
          put_pkt(r, PK_CON, '0, '0);
          r.timer_cmd = TM_CONN;
          ph = PH_CONSENT;
        end
        CMD_CLOSE: if (ph != PH_IDLE) begin
          put_pkt(r, PK_FIN, '0, '0);
          ph = PH_IDLE;
        end
        CMD_SEND: if (send_open && ph == PH_CONNECTED) begin
          send_open = 1'b0;
          put_pkt(r, PK_DATA, w, s);
          held_word = w;
          held_size = s;
          r.timer_cmd = TM_DATA;
          ph = PH_SENDING;
        end
        default: begin
          if (give) begin
            if (ph == PH_SENDING) begin
              r.timer_cmd = TM_STOP;
              retries   = '0;
              send_open = 1'b1;
              ph = PH_CONNECTED;
            end
          end else if (ph == PH_CONSENT) begin
            put_pkt(r, PK_FIN, '0, '0);
            ph = PH_IDLE;
          end else if (ph == PH_CONNECTED) begin
            r.timer_cmd = TM_DATA;
            ph = PH_SENDING;
          end else if (ph == PH_SENDING) begin
            // resend of the held word
            send_open = 1'b0;
            retries   = retries + 1'b1;
            put_pkt(r, PK_DATA, held_word, held_size);
            r.timer_cmd = TM_DATA;
          end
        end
      endcase
      r.link_state = ph;
      r.send_ready = send_open;
      if (r.send_valid || r.timer_cmd != TM_NONE || r.deliver_valid || r.gave_up ||
          ph != old_ph)
        active_events++;
      exp_results.push_back(r);
    endfunction

    task report(input string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task cmp(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
        report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(input result_t got);
      result_t want;
      if (exp_results.size() == 0) begin
        report("result transaction with nothing expected");
        return;
      end
      want = exp_results.pop_front();
      cmp("send_valid", got.send_valid, want.send_valid);
      cmp("send_type", got.send_type, want.send_type);
      cmp("send_word", got.send_word, want.send_word);
      cmp("send_size", got.send_size, want.send_size);
      cmp("timer_cmd", got.timer_cmd, want.timer_cmd);
      cmp("deliver_valid", got.deliver_valid, want.deliver_valid);
      cmp("deliver_word", got.deliver_word, want.deliver_word);
      cmp("deliver_size", got.deliver_size, want.deliver_size);
      cmp("link_state", got.link_state, want.link_state);
      cmp("send_ready", got.send_ready, want.send_ready);
      cmp("gave_up", got.gave_up, want.gave_up);
    endtask
  endclass

endpackage

FILE: verif/stop_and_wait_link_fsm_core_test.sv
`timescale 1ns / 100ps
// self-checking test of stop_and_wait_link_fsm_core: directed link events, then
// state-aware random event streams under several retransmit limits
// depends on saw_pkg, saw_link_sb_pkg and the link controller rtl
module stop_and_wait_link_fsm_core_test;

  import saw_pkg::*;
  import saw_link_sb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd = '0;
  logic [WORD_W-1:0] in_data_word = '0;
  logic [SIZE_W-1:0] in_data_size = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_send_valid;
  logic [1:0]        out_send_type;
  logic [WORD_W-1:0] out_send_word;
  logic [SIZE_W-1:0] out_send_size;
  logic [1:0]        out_timer_cmd;
  logic              out_deliver_valid;
  logic [WORD_W-1:0] out_deliver_word;
  logic [SIZE_W-1:0] out_deliver_size;
  logic [1:0]        out_link_state;
  logic              out_send_ready;
  logic              out_gave_up;
  logic              cfg_we = 1'b0;
  logic [CNT_W-1:0]  cfg_data = '0;

  link_scoreboard sb;
  bit sender_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  bit hold_request = 1'b0;
  int cycles = 0;

  stop_and_wait_link_fsm_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_data_word      (in_data_word),
    .in_data_size      (in_data_size),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_send_valid    (out_send_valid),
    .out_send_type     (out_send_type),
    .out_send_word     (out_send_word),
    .out_send_size     (out_send_size),
    .out_timer_cmd     (out_timer_cmd),
    .out_deliver_valid (out_deliver_valid),
    .out_deliver_word  (out_deliver_word),
    .out_deliver_size  (out_deliver_size),
    .out_link_state    (out_link_state),
    .out_send_ready    (out_send_ready),
    .out_gave_up       (out_gave_up),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result check first, then the event of the same edge
  always @(posedge clk) begin : monitor
    result_t got;
    if (rst_n === 1'b1 && sb != null) begin
      if (out_valid === 1'b1 && out_ready) begin
        got.send_valid    = out_send_valid;
        got.send_type     = pkt_t'(out_send_type);
        got.send_word     = out_send_word;
        got.send_size     = out_send_size;
        got.timer_cmd     = tmr_t'(out_timer_cmd);
        got.deliver_valid = out_deliver_valid;
        got.deliver_word  = out_deliver_word;
        got.deliver_size  = out_deliver_size;
        got.link_state    = phase_t'(out_link_state);
        got.send_ready    = out_send_ready;
        got.gave_up       = out_gave_up;
        sb.check_result(got);
      end
      if (in_valid && in_ready === 1'b1)
        sb.note_event(cmd_t'(in_cmd), in_data_word, in_data_size);
    end
  end

  initial begin : receiver
    int n;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_event(input cmd_t c, input logic [WORD_W-1:0] w,
                             input logic [SIZE_W-1:0] s);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= c;
    in_data_word <= w;
    in_data_size <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
  endtask

  // mostly well-formed link traffic, with some noise
  task automatic pick_event(output cmd_t c, output logic [WORD_W-1:0] w,
                            output logic [SIZE_W-1:0] s);
    int r;
    r = $urandom_range(0, 99);
    w = $urandom;
    case ($urandom_range(0, 3))
      0: s = SIZE_W'($urandom_range(0, 15));
      1: s = SIZE_W'($urandom_range(480, 511));
      default: s = SIZE_W'($urandom_range(0, 511));
    endcase
    if (r < 12) begin
      c = cmd_t'($urandom_range(0, 7));
    end else begin
      case (sb.ph)
        PH_IDLE: c = (r < 70) ? CMD_CONNECT : (r < 88) ? CMD_RCV_CON : CMD_TIMER;
        PH_CONSENT: c = (r < 50) ? CMD_RCV_ACK : (r < 70) ? CMD_RCV_CON :
                        (r < 90) ? CMD_TIMER : CMD_RCV_FIN;
        PH_CONNECTED: c = (r < 45) ? CMD_SEND : (r < 70) ? CMD_RCV_DATA :
                          (r < 85) ? CMD_TIMER : (r < 93) ? CMD_RCV_FIN : CMD_CLOSE;
        default: c = (r < 45) ? CMD_TIMER : (r < 70) ? CMD_RCV_ACK :
                     (r < 85) ? CMD_RCV_DATA : (r < 95) ? CMD_SEND : CMD_CLOSE;
      endcase
    end
    case ($urandom_range(0, 7))
      0: if (sb.rx_seen) w = sb.rx_word;
      1: w = '0;
      2: w = '1;
      default: ;
    endcase
  endtask

  task automatic run_random(input int n);
    cmd_t              c;
    logic [WORD_W-1:0] w;
    logic [SIZE_W-1:0] s;
    int                goal;
    goal = sb.active_events + n;
    while (sb.active_events < goal) begin
      pick_event(c, w, s);
      drive_event(c, w, s);
    end
  endtask

  task automatic run_directed();
    int k;
    drive_event(CMD_SEND, 32'h1234_5678, 9'd8);
    drive_event(CMD_RCV_ACK, '0, '0);
    drive_event(CMD_TIMER, '0, '0);
    drive_event(CMD_CONNECT, '0, '0);
    drive_event(CMD_TIMER, '0, '0);
    drive_event(CMD_CONNECT, '0, '0);
    drive_event(CMD_RCV_CON, '0, '0);
    drive_event(CMD_SEND, '1, '1);
    drive_event(CMD_SEND, '0, '0);
    for (k = 0; k < RETRY_LIMIT_RST + 1; k++) drive_event(CMD_TIMER, $urandom, '0);
    drive_event(CMD_RCV_DATA, '0, '0);
    drive_event(CMD_RCV_DATA, '0, 9'd7);
    drive_event(CMD_RCV_DATA, '1, 9'd500);
    drive_event(CMD_TIMER, '0, '0);
    drive_event(CMD_RCV_ACK, '0, '0);
    drive_event(CMD_SEND, 32'hA5A5_A5A5, 9'd1);
    drive_event(CMD_RCV_DATA, 32'h5A5A_5A5A, 9'd501);
    drive_event(CMD_CLOSE, '0, '0);
    drive_event(CMD_RCV_CON, '0, '0);
    drive_event(CMD_RCV_FIN, '0, '0);
  endtask

  initial begin : main
    int k;
    sb = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    write_limit(4'd0);
    run_random(250);
    write_limit(4'd15);
    run_random(400);
    write_limit(4'd3);
    hold_request = 1'b1;
    run_random(200);
    for (k = 0; k < 3; k++) begin
      write_limit(CNT_W'($urandom_range(0, 15)));
      run_random(250);
    end
    write_limit(4'd1);
    sender_gaps = 1'b0;
    rx_stalls   = 1'b0;
    run_random(200);
    drain_results();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
